[design/asfc_pkg.sv]
// Shared types, register indexes and conversion constants of the sample format converter.
package asfc_pkg;

    localparam int WORD_W = 32;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_SOURCE_IS_FLOAT = 2'd0;
    localparam logic [1:0] REG_SOURCE_BITS     = 2'd1;
    localparam logic [1:0] REG_OUTPUT_FORMAT   = 2'd2;

    // Output format codes; the unused code behaves as float32
    localparam logic [1:0] FMT_S16 = 2'd0;
    localparam logic [1:0] FMT_S32 = 2'd1;
    localparam logic [1:0] FMT_F32 = 2'd2;

    localparam logic [5:0] DEFAULT_BITS = 6'd16;
    localparam logic [5:0] S16_BITS     = 6'd16;
    localparam logic [5:0] S32_BITS     = 6'd32;

    localparam logic [30:0] K16 = 31'd32767;
    localparam logic [30:0] K32 = 31'h7FFF_FFFF;

    localparam logic signed [63:0] S16_HI = 64'sd32767;
    localparam logic signed [63:0] S16_LO = -64'sd32768;
    localparam logic signed [63:0] S32_HI = 64'sd2147483647;
    localparam logic signed [63:0] S32_LO = -64'sd2147483648;

    localparam logic [31:0] S16_MAX_W = 32'h0000_7FFF;
    localparam logic [31:0] S16_MIN_W = 32'hFFFF_8000;
    localparam logic [31:0] S32_MAX_W = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN_W = 32'h8000_0000;

    localparam logic [30:0] F32_ONE_MAG = 31'h3F80_0000;
    localparam logic [31:0] F32_POS_MAX = 32'h3F7F_FFFF;
    localparam logic [31:0] F32_NEG_ONE = 32'hBF80_0000;

    typedef struct packed {
        logic       source_is_float;
        logic [5:0] source_bits;
        logic [1:0] output_format;
    } cfg_t;

    // Per-stage load enables from the flow control to the datapath
    typedef struct packed {
        logic [3:0] load;
    } adv_t;

endpackage

[design/asfc_if.sv]
// Channel interfaces of the sample format converter: input samples, results, configuration.
interface asfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_word;

    modport source (output valid, output sample_word, input ready);
    modport sink   (input valid, input sample_word, output ready);
endinterface

interface asfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;

    modport source (output valid, output out_word, input ready);
    modport sink   (input valid, input out_word, output ready);
endinterface

interface asfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/audio_sample_format_converter.sv]
// Top level of the sample format converter: configuration registers and pipeline flow control.
//
//  channel  modport  payload              purpose
//  src      sink     sample_word[31:0]    raw sample, integer or float32 bits
//  dst      source   out_word[31:0]       converted sample
//  cfg      sink     index[1:0], data     register write, always ready
//
// Each sample passes the stages below in order to its result; one sample per cycle sustained while dst.ready holds.
// The stages are multiply, product rounding, alignment shift and final rounding with select.
// Each stage holds while the next one is full and stalled, so a bubble is filled at once.
// Reset clears the valid bits and the registers (integer source, bit count 0 meaning 16, S16 output).
module audio_sample_format_converter
    import asfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    asfc_in_if.sink           src,
    asfc_out_if.source        dst,
    asfc_cfg_if.sink          cfg
);

    cfg_t       cfg_reg;
    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    logic [3:0] stage_ready;
    adv_t       adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SOURCE_IS_FLOAT: cfg_reg.source_is_float <= cfg.data[0];
                REG_SOURCE_BITS:     cfg_reg.source_bits     <= cfg.data[5:0];
                REG_OUTPUT_FORMAT:   cfg_reg.output_format   <= cfg.data[1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // A stage can take a transaction when empty or when its content moves on
    assign stage_ready[3] = !valid_reg[3] || dst.ready;
    assign stage_ready[2] = !valid_reg[2] || stage_ready[3];
    assign stage_ready[1] = !valid_reg[1] || stage_ready[2];
    assign stage_ready[0] = !valid_reg[0] || stage_ready[1];

    assign adv.load[0] = src.valid && stage_ready[0];
    assign adv.load[1] = valid_reg[0] && stage_ready[1];
    assign adv.load[2] = valid_reg[1] && stage_ready[2];
    assign adv.load[3] = valid_reg[2] && stage_ready[3];

    assign valid_next[0] = adv.load[0] || (valid_reg[0] && !adv.load[1]);
    assign valid_next[1] = adv.load[1] || (valid_reg[1] && !adv.load[2]);
    assign valid_next[2] = adv.load[2] || (valid_reg[2] && !adv.load[3]);
    assign valid_next[3] = adv.load[3] || (valid_reg[3] && !dst.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 4'd0;
        else
            valid_reg <= valid_next;
    end

    assign src.ready = stage_ready[0];
    assign dst.valid = valid_reg[3];

    asfc_core u_core
    (
        .clk         (clk),
        .cfg         (cfg_reg),
        .ctl         (adv),
        .sample_word (src.sample_word),
        .out_word    (dst.out_word)
    );

endmodule

[design/asfc_core.sv]
// Four-stage conversion datapath: decode and multiply, round, align, final round and select.
module asfc_core
    import asfc_pkg::*;
(
    input  logic        clk,
    input  cfg_t        cfg,
    input  adv_t        ctl,
    input  logic [31:0] sample_word,
    output logic [31:0] out_word
);

    // Normalise a 32-bit magnitude in five halving steps
    function automatic logic [36:0] norm32(input logic [31:0] m_in);
        logic [31:0] m;
        logic [4:0]  lz;
        m  = m_in;
        lz = 5'd0;
        if (m[31:16] == 16'd0) begin m = m << 16; lz[4] = 1'b1; end
        if (m[31:24] == 8'd0)  begin m = m << 8;  lz[3] = 1'b1; end
        if (m[31:28] == 4'd0)  begin m = m << 4;  lz[2] = 1'b1; end
        if (m[31:30] == 2'd0)  begin m = m << 2;  lz[1] = 1'b1; end
        if (m[31] == 1'b0)     begin m = m << 1;  lz[0] = 1'b1; end
        return {lz, m};
    endfunction

    logic       fmt_s16;
    logic       to_int;
    logic [5:0] eff_bits;

    assign fmt_s16  = (cfg.output_format == FMT_S16);
    assign to_int   = fmt_s16 || (cfg.output_format == FMT_S32);
    assign eff_bits = (cfg.source_bits == 6'd0) ? DEFAULT_BITS : cfg.source_bits;

    // ---------------- stage 1: decode, multiply, integer shift
    logic [23:0]        mant24;
    logic [30:0]        scale_k;
    logic [8:0]         sh_full;
    logic [5:0]         tgt;
    logic [5:0]         rdiff;
    logic [4:0]         lsh;
    logic [4:0]         rsh;
    logic signed [63:0] ext;
    logic [54:0]        prod_next;
    logic [5:0]         sh_next;
    logic signed [63:0] v_next;
    logic [31:0]        mag_next;

    logic [31:0]        s1_word_reg;
    logic [54:0]        s1_prod_reg;
    logic [5:0]         s1_sh_reg;
    logic signed [63:0] s1_v_reg;
    logic [31:0]        s1_mag_reg;

    assign mant24    = {1'b1, sample_word[22:0]};
    assign scale_k   = fmt_s16 ? K16 : K32;
    assign prod_next = 55'(mant24) * 55'(scale_k);
    assign sh_full   = 9'd150 - {1'b0, sample_word[30:23]};
    assign sh_next   = (sh_full > 9'd63) ? 6'd63 : sh_full[5:0];

    assign tgt   = fmt_s16 ? S16_BITS : S32_BITS;
    assign rdiff = eff_bits - tgt;
    assign lsh   = (eff_bits < tgt) ? 5'(tgt - eff_bits) : 5'd0;
    assign rsh   = (eff_bits > tgt) ? ((rdiff > 6'd31) ? 5'd31 : rdiff[4:0]) : 5'd0;
    assign ext   = 64'(signed'(sample_word));
    assign v_next   = (ext <<< lsh) >>> rsh;
    assign mag_next = sample_word[31] ? (~sample_word + 32'd1) : sample_word;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s1_word_reg <= sample_word;
            s1_prod_reg <= prod_next;
            s1_sh_reg   <= sh_next;
            s1_v_reg    <= v_next;
            s1_mag_reg  <= mag_next;
        end
    end

    // ---------------- stage 2: round product, saturate integer, normalise magnitude
    logic [5:0]  lp;
    logic [54:0] q;
    logic [54:0] gbits;
    logic [54:0] pmask;
    logic        p_inc;
    logic [55:0] pr_next;
    logic [31:0] ires_next;
    logic [36:0] nz;

    logic [31:0] s2_word_reg;
    logic [55:0] s2_pr_reg;
    logic [5:0]  s2_sh_reg;
    logic [31:0] s2_ires_reg;
    logic [31:0] s2_norm_reg;
    logic [4:0]  s2_lz_reg;

    always_comb
    begin
        if (fmt_s16)
            lp = s1_prod_reg[38] ? 6'd15 : 6'd14;
        else
            lp = s1_prod_reg[54] ? 6'd2 : 6'd1;
    end

    assign q       = s1_prod_reg >> lp;
    assign gbits   = s1_prod_reg >> (lp - 6'd1);
    assign pmask   = (55'd1 << (lp - 6'd1)) - 55'd1;
    assign p_inc   = gbits[0] & ((|(s1_prod_reg & pmask)) | q[0]);
    assign pr_next = (56'(q) + 56'(p_inc)) << lp;

    always_comb
    begin
        if (fmt_s16)
        begin
            if (s1_v_reg > S16_HI)
                ires_next = S16_MAX_W;
            else if (s1_v_reg < S16_LO)
                ires_next = S16_MIN_W;
            else
                ires_next = {{16{s1_v_reg[15]}}, s1_v_reg[15:0]};
        end
        else
        begin
            if (s1_v_reg > S32_HI)
                ires_next = S32_MAX_W;
            else if (s1_v_reg < S32_LO)
                ires_next = S32_MIN_W;
            else
                ires_next = s1_v_reg[31:0];
        end
    end

    assign nz = norm32(s1_mag_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            s2_word_reg <= s1_word_reg;
            s2_pr_reg   <= pr_next;
            s2_sh_reg   <= s1_sh_reg;
            s2_ires_reg <= ires_next;
            s2_norm_reg <= nz[31:0];
            s2_lz_reg   <= nz[36:32];
        end
    end

    // ---------------- stage 3: align product to the integer point, round int to float
    logic [63:0] pe;
    logic [63:0] n_full;
    logic [63:0] hs;
    logic [63:0] amask;
    logic [8:0]  e9;
    logic        f_inc;
    logic [30:0] fmag;
    logic [31:0] fres_next;

    logic [31:0] s3_word_reg;
    logic [31:0] s3_n_reg;
    logic        s3_half_reg;
    logic        s3_st_reg;
    logic [31:0] s3_ires_reg;
    logic [31:0] s3_fres_reg;

    assign pe     = 64'(s2_pr_reg);
    assign n_full = pe >> s2_sh_reg;
    assign hs     = pe >> (s2_sh_reg - 6'd1);
    assign amask  = (64'd1 << (s2_sh_reg - 6'd1)) - 64'd1;

    assign e9    = 9'd159 - 9'(s2_lz_reg) - 9'(eff_bits);
    assign f_inc = s2_norm_reg[7] & ((|s2_norm_reg[6:0]) | s2_norm_reg[8]);
    assign fmag  = {e9[7:0], s2_norm_reg[30:8]} + 31'(f_inc);

    always_comb
    begin
        if (!s2_norm_reg[31])
            fres_next = 32'd0;
        else if (fmag >= F32_ONE_MAG)
            fres_next = s2_word_reg[31] ? F32_NEG_ONE : F32_POS_MAX;
        else
            fres_next = {s2_word_reg[31], fmag};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            s3_word_reg <= s2_word_reg;
            s3_n_reg    <= n_full[31:0];
            s3_half_reg <= hs[0];
            s3_st_reg   <= |(pe & amask);
            s3_ires_reg <= s2_ires_reg;
            s3_fres_reg <= fres_next;
        end
    end

    // ---------------- stage 4: final rounding, special cases, format select
    logic        f_nan;
    logic        f_big;
    logic        f_tiny;
    logic        n_inc;
    logic [31:0] n_rnd;
    logic [31:0] fint;
    logic [31:0] out_next;
    logic [31:0] out_word_reg;

    assign f_nan  = (&s3_word_reg[30:23]) && (|s3_word_reg[22:0]);
    assign f_big  = (s3_word_reg[30:23] >= 8'd127);
    assign f_tiny = (s3_word_reg[30:23] == 8'd0);
    // half to even for 16-bit, half away from zero for 32-bit
    assign n_inc  = fmt_s16 ? (s3_half_reg & (s3_st_reg | s3_n_reg[0])) : s3_half_reg;
    assign n_rnd  = s3_n_reg + 32'(n_inc);

    always_comb
    begin
        if (f_nan || f_tiny)
            fint = 32'd0;
        else if (f_big)
        begin
            if (s3_word_reg[31])
                fint = fmt_s16 ? S16_MIN_W : S32_MIN_W;
            else
                fint = fmt_s16 ? S16_MAX_W : S32_MAX_W;
        end
        else
            fint = s3_word_reg[31] ? (~n_rnd + 32'd1) : n_rnd;
    end

    always_comb
    begin
        if (cfg.source_is_float)
            out_next = to_int ? fint : s3_word_reg;
        else
            out_next = to_int ? s3_ires_reg : s3_fres_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
            out_word_reg <= out_next;
    end

    assign out_word = out_word_reg;

endmodule

[design/asfc_checker.sv]
// Port-level checks of the sample format converter, bound to the top level.
module asfc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        src_valid,
    input logic        src_ready,
    input logic        dst_valid,
    input logic        dst_ready,
    input logic [31:0] out_word
);

    // No result is shown while reset is applied
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !dst_valid)
        else $error("result valid during reset");

    // With the output register empty the whole pipeline must flow
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> src_ready)
        else $error("input stalled with empty output");

    // A transaction reaches the output through all stages when dst_ready stays high meanwhile
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && src_ready) ##1 dst_ready ##1 dst_ready ##1 dst_ready |=> dst_valid)
        else $error("result missing four cycles after input transaction");

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_ready) |=> (dst_valid && $stable(out_word)))
        else $error("stalled result dropped or changed");

endmodule

bind audio_sample_format_converter asfc_checker u_asfc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src.valid),
    .src_ready (src.ready),
    .dst_valid (dst.valid),
    .dst_ready (dst.ready),
    .out_word  (dst.out_word)
);

[test/audio_sample_format_converter_tb.sv]
// Self-checking testbench of the sample format converter: directed table, then random phases.
module audio_sample_format_converter_tb
    import asfc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1050;
    localparam int PHASE_LEN   = 70;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic        is_float;
        logic [5:0]  bits;
        logic [1:0]  fmt;
        logic [31:0] word;
        logic        typed;
        logic [31:0] want;
    } row_t;

    localparam int N_ROWS = 25;
    localparam row_t DIRECTED [N_ROWS] = '{
        '{1'b0, 6'd0,  FMT_S16, 32'h0000_7FFF, 1'b1, 32'h0000_7FFF},
        '{1'b0, 6'd0,  FMT_S16, 32'hFFFF_8000, 1'b1, 32'hFFFF_8000},
        '{1'b0, 6'd0,  FMT_S16, 32'h0001_2345, 1'b1, 32'h0000_7FFF},
        '{1'b0, 6'd24, FMT_S16, 32'hFF80_0000, 1'b1, 32'hFFFF_8000},
        '{1'b0, 6'd24, FMT_S16, 32'h0012_3456, 1'b0, 32'h0},
        '{1'b0, 6'd8,  FMT_S32, 32'h0000_007F, 1'b1, 32'h7F00_0000},
        '{1'b0, 6'd8,  FMT_S32, 32'hFFFF_FFFF, 1'b1, 32'hFF00_0000},
        '{1'b0, 6'd8,  FMT_S32, 32'h0000_0100, 1'b1, 32'h7FFF_FFFF},
        '{1'b0, 6'd63, FMT_S16, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF},
        '{1'b0, 6'd63, FMT_S16, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
        '{1'b0, 6'd32, FMT_F32, 32'h8000_0000, 1'b1, 32'hBF80_0000},
        '{1'b0, 6'd32, FMT_F32, 32'h7FFF_FFFF, 1'b1, 32'h3F7F_FFFF},
        '{1'b0, 6'd32, FMT_F32, 32'h1234_5678, 1'b0, 32'h0},
        '{1'b0, 6'd16, 2'd3,    32'h0000_4000, 1'b1, 32'h3F00_0000},
        '{1'b0, 6'd1,  FMT_F32, 32'hFFFF_FFFF, 1'b1, 32'hBF80_0000},
        '{1'b0, 6'd1,  FMT_F32, 32'h0000_0001, 1'b1, 32'h3F7F_FFFF},
        '{1'b1, 6'd5,  FMT_S16, 32'h3F80_0000, 1'b1, 32'h0000_7FFF},
        '{1'b1, 6'd5,  FMT_S16, 32'hFF80_0000, 1'b1, 32'hFFFF_8000},
        '{1'b1, 6'd5,  FMT_S16, 32'h7FC0_0000, 1'b1, 32'h0000_0000},
        '{1'b1, 6'd5,  FMT_S16, 32'h3F00_0000, 1'b1, 32'h0000_4000},
        '{1'b1, 6'd0,  FMT_S32, 32'h7F80_0000, 1'b1, 32'h7FFF_FFFF},
        '{1'b1, 6'd0,  FMT_S32, 32'hC000_0000, 1'b1, 32'h8000_0000},
        '{1'b1, 6'd0,  FMT_S32, 32'h3F00_0000, 1'b1, 32'h4000_0000},
        '{1'b1, 6'd0,  FMT_S32, 32'h3E12_3457, 1'b0, 32'h0},
        '{1'b1, 6'd0,  FMT_F32, 32'h7FC0_1234, 1'b1, 32'h7FC0_1234}
    };

    logic clk;
    logic rst_n;

    asfc_in_if  src_ch ();
    asfc_out_if dst_ch ();
    asfc_cfg_if cfg_ch ();

    audio_sample_format_converter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch.sink),
        .dst   (dst_ch.source),
        .cfg   (cfg_ch.sink)
    );

    cfg_t        conv_cfg;
    logic [31:0] pending_words [$];
    logic        word_typed;
    logic [31:0] word_want;
    bit          steady;
    bit          hold_req;
    int          n_samples;
    int          n_results;
    int          n_writes;
    int          n_mismatch;
    int          idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic real pow2(int k);
        return $bitstoreal({1'b0, 11'(1023 + k), 52'b0});
    endfunction

    function automatic real single_value(logic [31:0] b);
        real mag;
        if (b[30:23] == 8'd0)
            mag = real'(int'(b[22:0])) * pow2(-149);
        else
            mag = real'(int'({1'b1, b[22:0]})) * pow2(int'(b[30:23]) - 150);
        return b[31] ? -mag : mag;
    endfunction

    // Round a double to single with ties to even; the caller keeps it in the normal range
    function automatic logic [31:0] single_bits(real v);
        logic [63:0] d;
        logic [24:0] keep;
        int          eu;
        d = $realtobits(v);
        if (d[62:0] == 63'd0)
            return {d[63], 31'd0};
        eu   = int'(d[62:52]) - 1023;
        keep = {2'b01, d[51:29]};
        if (d[28:0] > 29'h1000_0000 || (d[28:0] == 29'h1000_0000 && keep[0]))
            keep = keep + 25'd1;
        if (keep[24])
        begin
            keep = keep >> 1;
            eu   = eu + 1;
        end
        return {d[63], 8'(eu + 127), keep[22:0]};
    endfunction

    function automatic logic [31:0] float_to_s16(logic [31:0] w);
        real x;
        real t;
        int  n;
        real frac;
        if (w[30:23] == 8'hFF && w[22:0] != 23'd0)
            return 32'd0;
        if (w[30:23] == 8'hFF)
            x = w[31] ? -2.0 : 2.0;
        else
            x = single_value(w);
        if (x <= -1.0)
            return S16_MIN_W;
        if (x > 1.0)
            x = 1.0;
        t = x * 32767.0;
        if (t < 0.25 && t > -0.25)
            return 32'd0;
        // product is rounded to single before the integer rounding
        t = single_value(single_bits(t));
        if (t < 0.0)
            t = -t;
        n    = $rtoi(t);
        frac = t - real'(n);
        if (frac > 0.5 || (frac == 0.5 && n[0]))
            n = n + 1;
        if (x < 0.0)
            n = -n;
        return 32'(n);
    endfunction

    function automatic logic [31:0] float_to_s32(logic [31:0] w);
        real    x;
        real    t;
        longint n;
        if (w[30:23] == 8'hFF && w[22:0] != 23'd0)
            return 32'd0;
        if (w[30:23] == 8'hFF)
            x = w[31] ? -2.0 : 2.0;
        else
            x = single_value(w);
        if (x <= -1.0)
            return S32_MIN_W;
        if (x > 1.0)
            x = 1.0;
        t = x * 2147483647.0;
        if (t < 0.0)
            t = -t;
        n = longint'($rtoi(t));
        if (t - real'(n) >= 0.5)
            n = n + 1;
        if (x < 0.0)
            n = -n;
        if (n > S32_HI)
            n = S32_HI;
        if (n < S32_LO)
            n = S32_LO;
        return n[31:0];
    endfunction

    function automatic logic [31:0] int_convert(logic [31:0] w, int bits, int target);
        longint v;
        int     sh;
        v = longint'(signed'(w));
        if (bits > target)
        begin
            sh = bits - target;
            if (sh > 62)
                sh = 62;
            v = v >>> sh;
        end
        else if (bits < target)
            v = v << (target - bits);
        if (target == 16)
        begin
            if (v > S16_HI) v = S16_HI;
            if (v < S16_LO) v = S16_LO;
        end
        else
        begin
            if (v > S32_HI) v = S32_HI;
            if (v < S32_LO) v = S32_LO;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] int_to_float(logic [31:0] w, int bits);
        real v;
        v = real'(int'(signed'(w))) / pow2(bits - 1);
        if (v < -1.0)
            v = -1.0;
        if (v > $bitstoreal(64'h3FEF_FFFF_E000_0000))
            v = $bitstoreal(64'h3FEF_FFFF_E000_0000);
        return single_bits(v);
    endfunction

    function automatic logic [31:0] convert_sample(cfg_t c, logic [31:0] w);
        int bits;
        bits = (c.source_bits == 6'd0) ? int'(DEFAULT_BITS) : int'(c.source_bits);
        if (c.source_is_float)
        begin
            if (c.output_format == FMT_S16)
                return float_to_s16(w);
            if (c.output_format == FMT_S32)
                return float_to_s32(w);
            return w;
        end
        if (c.output_format == FMT_S16)
            return int_convert(w, bits, 16);
        if (c.output_format == FMT_S32)
            return int_convert(w, bits, 32);
        return int_to_float(w, bits);
    endfunction

    // Mirror register writes, predict on every input transaction, check every result
    always @(posedge clk)
    begin
        if (cfg_ch.valid && cfg_ch.ready)
        begin
            n_writes <= n_writes + 1;
            case (cfg_ch.index)
                REG_SOURCE_IS_FLOAT: conv_cfg.source_is_float = cfg_ch.data[0];
                REG_SOURCE_BITS:     conv_cfg.source_bits     = cfg_ch.data[5:0];
                REG_OUTPUT_FORMAT:   conv_cfg.output_format   = cfg_ch.data[1:0];
                default: ;
            endcase
        end
        if (src_ch.valid && src_ch.ready)
        begin
            n_samples <= n_samples + 1;
            pending_words.push_back(word_typed ? word_want
                                               : convert_sample(conv_cfg, src_ch.sample_word));
        end
        if (dst_ch.valid && dst_ch.ready)
        begin
            n_results <= n_results + 1;
            if (pending_words.size() == 0)
            begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10)
                    $display("unexpected result out_word=%h", dst_ch.out_word);
            end
            else if (pending_words[0] !== dst_ch.out_word)
            begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10)
                    $display("out_word mismatch: expected %h, got %h",
                             pending_words[0], dst_ch.out_word);
                void'(pending_words.pop_front());
            end
            else
                void'(pending_words.pop_front());
        end
        if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, long hold-off on request
    initial
    begin
        dst_ch.ready <= 1'b0;
        @(negedge rst_n);
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                dst_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                dst_ch.ready <= steady || ($urandom_range(0, 99) >= 36);
                @(posedge clk);
            end
        end
    end

    task automatic send_sample(logic [31:0] w, logic typed, logic [31:0] want);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid       <= 1'b1;
        src_ch.sample_word <= w;
        word_typed         <= typed;
        word_want          <= want;
        @(posedge clk);
        while (!src_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Drain the pipeline, then load all three registers
    task automatic load_setting(logic is_float, logic [5:0] bits, logic [1:0] fmt);
        src_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        write_reg(REG_SOURCE_IS_FLOAT, {31'd0, is_float});
        write_reg(REG_SOURCE_BITS, {26'd0, bits});
        write_reg(REG_OUTPUT_FORMAT, {30'd0, fmt});
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_float();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0, 1: w[30:23] = 8'($urandom_range(100, 126));
            2:    w[30:23] = 8'($urandom_range(126, 128));
            3:    w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            4:    w = $urandom_range(0, 1) ? {w[31], 31'h3F80_0000} : {w[31], 31'h3F00_0000};
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] random_int(logic [5:0] bits);
        int          b;
        logic [31:0] w;
        b = (bits == 6'd0) ? 16 : int'(bits);
        w = $urandom;
        if (b < 32 && $urandom_range(0, 3) != 0)
            w = 32'($signed(w << (32 - b)) >>> (32 - b));
        return w;
    endfunction

    initial
    begin
        int          sent;
        int          phase;
        logic        is_float;
        logic [5:0]  bits;
        logic [1:0]  fmt;
        cfg_t        last;
        conv_cfg     = '0;
        n_samples    = 0;
        n_results    = 0;
        n_writes     = 0;
        n_mismatch   = 0;
        idle_cycles  = 0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        rst_n        = 1'b1;
        src_ch.valid       <= 1'b0;
        src_ch.sample_word <= '0;
        word_typed         <= 1'b0;
        word_want          <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_SOURCE_IS_FLOAT;
        cfg_ch.data        <= '0;
        // apply reset ahead of the first clock edge
        #1;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // first rows run on the reset setting
        last = '{source_is_float: 1'b0, source_bits: 6'd0, output_format: FMT_S16};
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (DIRECTED[i].is_float != last.source_is_float ||
                DIRECTED[i].bits != last.source_bits || DIRECTED[i].fmt != last.output_format)
            begin
                load_setting(DIRECTED[i].is_float, DIRECTED[i].bits, DIRECTED[i].fmt);
                last = '{DIRECTED[i].is_float, DIRECTED[i].bits, DIRECTED[i].fmt};
            end
            send_sample(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
        end

        sent  = 0;
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            is_float = $urandom_range(0, 1);
            case ($urandom_range(0, 6))
                0: bits = 6'd0;
                1: bits = 6'd1;
                2: bits = 6'd32;
                3: bits = 6'd63;
                4: bits = 6'd24;
                default: bits = 6'($urandom_range(0, 63));
            endcase
            fmt = 2'($urandom_range(0, 3));
            load_setting(is_float, bits, fmt);
            steady = (phase == 5 || phase == 6);
            if (phase == 3)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                send_sample(is_float ? random_float() : random_int(bits), 1'b0, '0);
                sent++;
            end
            steady = 1'b0;
            phase++;
        end
        src_ch.valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered %0d samples, %0d results, %0d register writes over %0d settings",
                 n_samples, n_results, n_writes, phase + 10);
        $display("integer and float sources, all output formats, stalls and a long hold-off");
        if (n_mismatch == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[audio_sample_format_converter.f]
design/asfc_pkg.sv
design/asfc_if.sv
design/asfc_core.sv
design/audio_sample_format_converter.sv
design/asfc_checker.sv
test/audio_sample_format_converter_tb.sv
